// ===== hdl/spcf_pkg.sv =====
package spcf_pkg;

    localparam int MAX_SPHERES_DEF = 8;

    localparam int COORD_W    = 16;
    localparam int RADIUS_W   = 16;
    localparam int TYPE_W     = 4;
    localparam int IN_DATA_W  = 3 * COORD_W + RADIUS_W;
    localparam int ENTRY_W    = IN_DATA_W + TYPE_W;
    localparam int OUT_IDX_W  = 3;
    localparam int OUT_DATA_W = 8;

    localparam int X_LO    = 0;
    localparam int Y_LO    = COORD_W;
    localparam int Z_LO    = 2 * COORD_W;
    localparam int RAD_LO  = 3 * COORD_W;
    localparam int TYPE_LO = IN_DATA_W;

    localparam logic [TYPE_W-1:0] TYPE_NONE = '0;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_DIFF,
        ST_SQ,
        ST_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic diff_en;
        logic sq_en;
        logic push_pair;
        logic push_done;
        logic ovf;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic out_free;
    } t_stat;

endpackage

// ===== hdl/spcf_ram.sv =====
module spcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/spcf_ctrl.sv =====
module spcf_ctrl import spcf_pkg::*; #(
    parameter int MAX_SPHERES = MAX_SPHERES_DEF,
    localparam int CW = $clog2(MAX_SPHERES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    input  t_stat         i_stat,
    output logic          o_in_ready,
    output t_cmd          o_cmd,
    output logic [CW-1:0] o_wr_idx,
    output logic [CW-1:0] o_idx_a,
    output logic [CW-1:0] o_idx_b
);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic          r_drop, n_drop;

    logic          take;
    logic          room;
    logic [CW-1:0] cnt_load;
    logic          last_pair;
    logic          last_row;
    logic          step;

    assign take      = i_in_valid && (r_state == ST_LOAD);
    assign room      = r_cnt < CW'(MAX_SPHERES);
    assign cnt_load  = room ? r_cnt + CW'(1) : r_cnt;
    assign last_pair = r_j == (r_cnt - CW'(1));
    // no row left once i + 2 reaches the count
    assign last_row  = ({1'b0, r_i} + (CW + 1)'(2)) >= {1'b0, r_cnt};
    assign step      = (r_state == ST_CMP) && (!i_stat.hit || i_stat.out_free);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (take && i_in_last) begin
                    n_state = (cnt_load >= CW'(2)) ? ST_READ : ST_DONE;
                end
            end
            ST_READ: n_state = ST_DIFF;
            ST_DIFF: n_state = ST_SQ;
            ST_SQ:   n_state = ST_CMP;
            ST_CMP: begin
                if (step) begin
                    n_state = (last_pair && last_row) ? ST_DONE : ST_READ;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        n_cnt  = r_cnt;
        n_drop = r_drop;
        n_i    = r_i;
        n_j    = r_j;
        case (r_state)
            ST_LOAD: begin
                if (take) begin
                    n_cnt = cnt_load;
                    n_i   = '0;
                    n_j   = CW'(1);
                    if (!room) begin
                        n_drop = 1'b1;
                    end
                end
            end
            ST_CMP: begin
                if (step) begin
                    if (last_pair) begin
                        n_i = r_i + CW'(1);
                        n_j = r_i + CW'(2);
                    end else begin
                        n_j = r_j + CW'(1);
                    end
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    n_cnt  = '0;
                    n_drop = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.ovf       = r_drop;
        o_in_ready      = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_in_ready   = 1'b1;
                o_cmd.wr_en  = take && room;
            end
            ST_READ: o_cmd.rd_en   = 1'b1;
            ST_DIFF: o_cmd.diff_en = 1'b1;
            ST_SQ:   o_cmd.sq_en   = 1'b1;
            ST_CMP:  o_cmd.push_pair = i_stat.hit && i_stat.out_free;
            ST_DONE: o_cmd.push_done = i_stat.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_drop  <= n_drop;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    assign o_wr_idx = r_cnt;
    assign o_idx_a  = r_i;
    assign o_idx_b  = r_j;

endmodule

// ===== hdl/spcf_dp.sv =====
module spcf_dp import spcf_pkg::*; #(
    parameter int MAX_SPHERES = MAX_SPHERES_DEF,
    localparam int IW = $clog2(MAX_SPHERES),
    localparam int CW = $clog2(MAX_SPHERES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [CW-1:0]         i_wr_idx,
    input  logic [CW-1:0]         i_idx_a,
    input  logic [CW-1:0]         i_idx_b,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic [TYPE_W-1:0]     i_in_type,
    input  logic                  i_out_ready,
    output t_stat                 o_stat,
    output logic                  o_out_valid,
    output logic [OUT_DATA_W-1:0] o_out_data,
    output logic                  o_out_ovf,
    output logic                  o_out_last
);

    localparam int SQ_W  = 2 * COORD_W;
    localparam int RS_W  = RADIUS_W + 1;
    localparam int RS2_W = 2 * RS_W;

    function automatic logic [COORD_W-1:0] abs_diff(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        logic        [COORD_W:0] m;
        d = $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});
        m = d[COORD_W] ? unsigned'(-d) : unsigned'(d);
        return m[COORD_W-1:0];
    endfunction

    logic [ENTRY_W-1:0] rd_a, rd_b;
    logic [ENTRY_W-1:0] wr_data;

    assign wr_data = {i_in_type, i_in_data};

    spcf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SPHERES)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (i_wr_idx[IW-1:0]),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_idx_a[IW-1:0]),
        .o_rdata (rd_a)
    );

    spcf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SPHERES)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (i_wr_idx[IW-1:0]),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_idx_b[IW-1:0]),
        .o_rdata (rd_b)
    );

    logic [TYPE_W-1:0] ta, tb;
    logic              types_ok;

    assign ta       = rd_a[TYPE_LO +: TYPE_W];
    assign tb       = rd_b[TYPE_LO +: TYPE_W];
    assign types_ok = (ta != TYPE_NONE) && (tb != TYPE_NONE) && (ta != tb);

    // stage 1: axis magnitudes and radius sum
    logic [COORD_W-1:0] r_dx, r_dy, r_dz;
    logic [RS_W-1:0]    r_rsum;
    logic               r_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff_en) begin
            r_dx   <= abs_diff(rd_a[X_LO +: COORD_W], rd_b[X_LO +: COORD_W]);
            r_dy   <= abs_diff(rd_a[Y_LO +: COORD_W], rd_b[Y_LO +: COORD_W]);
            r_dz   <= abs_diff(rd_a[Z_LO +: COORD_W], rd_b[Z_LO +: COORD_W]);
            r_rsum <= RS_W'(rd_a[RAD_LO +: RADIUS_W]) + RS_W'(rd_b[RAD_LO +: RADIUS_W]);
            r_ok   <= types_ok;
        end
    end

    // stage 2: squares
    logic [SQ_W-1:0]  r_sx, r_sy, r_sz;
    logic [RS2_W-1:0] r_rs2;
    logic             r_ok2;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_en) begin
            r_sx  <= SQ_W'(r_dx * r_dx);
            r_sy  <= SQ_W'(r_dy * r_dy);
            r_sz  <= SQ_W'(r_dz * r_dz);
            r_rs2 <= RS2_W'(r_rsum * r_rsum);
            r_ok2 <= r_ok;
        end
    end

    // stage 3: distance sum against squared radius sum
    logic [RS2_W-1:0] d2;

    assign d2 = RS2_W'(r_sx) + RS2_W'(r_sy) + RS2_W'(r_sz);

    logic                 r_out_valid;
    logic [OUT_IDX_W-1:0] r_first, r_second;
    logic                 r_ovf;
    logic                 r_last;

    assign o_stat.hit      = r_ok2 && (d2 <= r_rs2);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push_pair || i_cmd.push_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_pair || i_cmd.push_done) begin
            r_first  <= i_cmd.push_pair ? OUT_IDX_W'(i_idx_a) : '0;
            r_second <= i_cmd.push_pair ? OUT_IDX_W'(i_idx_b) : '0;
            r_last   <= i_cmd.push_done;
            r_ovf    <= i_cmd.push_done && i_cmd.ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = OUT_DATA_W'({r_second, r_first});
    assign o_out_ovf   = r_ovf;
    assign o_out_last  = r_last;

endmodule

// ===== hdl/sphere_pair_collision_finder_core.sv =====
// while loading, a sphere is taken whenever one is offered; after frame end each
// stored pair passes in turn through the read, diff, square and compare states of
// the shared path, so a frame of n spheres makes n*(n-1)/2 sweeps plus output stalls
// no sphere is taken from frame end until the done item has entered the output register
// synchronous active-low reset clears the sequencer, count, drop flag and output valid;
// the sphere store is not cleared
module sphere_pair_collision_finder_core import spcf_pkg::*; #(
    parameter int MAX_SPHERES = MAX_SPHERES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // pos_x, pos_y, pos_z, radius
    input  logic [TYPE_W-1:0]     s_axis_tuser,  // type_tag
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // first_index, second_index, zero pad
    output logic                  m_axis_tuser,  // overflow
    output logic                  m_axis_tlast
);

    localparam int CW = $clog2(MAX_SPHERES + 1);

    t_cmd          cmd;
    t_stat         stat;
    logic [CW-1:0] wr_idx, idx_a, idx_b;

    spcf_ctrl #(.MAX_SPHERES(MAX_SPHERES)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .o_wr_idx   (wr_idx),
        .o_idx_a    (idx_a),
        .o_idx_b    (idx_b)
    );

    spcf_dp #(.MAX_SPHERES(MAX_SPHERES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_wr_idx    (wr_idx),
        .i_idx_a     (idx_a),
        .i_idx_b     (idx_b),
        .i_in_data   (s_axis_tdata),
        .i_in_type   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_ovf   (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule

// ===== hdl/spcf_checker.sv =====
module spcf_checker import spcf_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic [TYPE_W-1:0]     s_axis_tuser,
    input logic                  s_axis_tlast,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser,
    input logic                  m_axis_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // the sweep closes the input side
    a_sweep_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("request taken during pair sweep");

    // input reopens only as the done item is presented
    a_reopen_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(s_axis_tready) |-> m_axis_tvalid && m_axis_tlast)
        else $error("input reopened without done item");

    a_done_no_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == '0)
        else $error("done item carries indices");

    a_pair_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser)
        else $error("overflow flag on pair item");

endmodule

bind sphere_pair_collision_finder_core spcf_checker u_spcf_checker (.*);
